FILE: rtl/ctks_pkg.sv
// Package for the C-like token splitter: payload structs, scan modes,
// token kind codes and character classes. Depends on nothing.
package ctks_pkg;

    // One input request: a source byte and the end-of-text flag.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    // One result request: a token with its position and length.
    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_of_run;
    } token_item_t;

    // Scanner modes.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_STR,
        MODE_STR_ESC,
        MODE_CHR_OPEN,
        MODE_CHR_ESC,
        MODE_CHR_CLOSE,
        MODE_DIR,
        MODE_LINE_CMT,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_OP
    } scan_mode_t;

    // Control part of the scanner state: mode and pending operator bytes.
    typedef struct packed {
        scan_mode_t mode;
        logic [7:0] op_first;
        logic       op_double;
    } scan_ctl_t;

    typedef logic [5:0] kind_t;

    localparam kind_t KIND_IDENT     = 6'd0;
    localparam kind_t KIND_INT       = 6'd1;
    localparam kind_t KIND_FLOAT     = 6'd2;
    localparam kind_t KIND_STRING    = 6'd3;
    localparam kind_t KIND_CHAR      = 6'd4;
    localparam kind_t KIND_DIRECTIVE = 6'd5;
    localparam kind_t KIND_ERROR     = 6'd6;
    localparam kind_t KIND_END       = 6'd7;
    localparam kind_t KIND_INC       = 6'd8;
    localparam kind_t KIND_ADD_EQ    = 6'd9;
    localparam kind_t KIND_ADD       = 6'd10;
    localparam kind_t KIND_DEC       = 6'd11;
    localparam kind_t KIND_SUB_EQ    = 6'd12;
    localparam kind_t KIND_ARROW     = 6'd13;
    localparam kind_t KIND_SUB       = 6'd14;
    localparam kind_t KIND_EQ_EQ     = 6'd15;
    localparam kind_t KIND_ASSIGN    = 6'd16;
    localparam kind_t KIND_NOT_EQ    = 6'd17;
    localparam kind_t KIND_NOT       = 6'd18;
    localparam kind_t KIND_LE        = 6'd19;
    localparam kind_t KIND_SHL_EQ    = 6'd20;
    localparam kind_t KIND_SHL       = 6'd21;
    localparam kind_t KIND_LT        = 6'd22;
    localparam kind_t KIND_GE        = 6'd23;
    localparam kind_t KIND_SHR_EQ    = 6'd24;
    localparam kind_t KIND_SHR       = 6'd25;
    localparam kind_t KIND_GT        = 6'd26;
    localparam kind_t KIND_LAND      = 6'd27;
    localparam kind_t KIND_AND_EQ    = 6'd28;
    localparam kind_t KIND_AND       = 6'd29;
    localparam kind_t KIND_LOR       = 6'd30;
    localparam kind_t KIND_OR_EQ     = 6'd31;
    localparam kind_t KIND_OR        = 6'd32;
    localparam kind_t KIND_XOR_EQ    = 6'd33;
    localparam kind_t KIND_XOR       = 6'd34;
    localparam kind_t KIND_TILDE     = 6'd35;
    localparam kind_t KIND_MUL_EQ    = 6'd36;
    localparam kind_t KIND_MUL       = 6'd37;
    localparam kind_t KIND_DIV_EQ    = 6'd38;
    localparam kind_t KIND_DIV       = 6'd39;
    localparam kind_t KIND_MOD_EQ    = 6'd40;
    localparam kind_t KIND_MOD       = 6'd41;
    localparam kind_t KIND_QUEST     = 6'd42;
    localparam kind_t KIND_SCOPE     = 6'd43;
    localparam kind_t KIND_COLON     = 6'd44;
    localparam kind_t KIND_SEMI      = 6'd45;
    localparam kind_t KIND_COMMA     = 6'd46;
    localparam kind_t KIND_DOT       = 6'd47;
    localparam kind_t KIND_LPAREN    = 6'd48;
    localparam kind_t KIND_RPAREN    = 6'd49;
    localparam kind_t KIND_LBRACE    = 6'd50;
    localparam kind_t KIND_RBRACE    = 6'd51;
    localparam kind_t KIND_LBRACKET  = 6'd52;
    localparam kind_t KIND_RBRACKET  = 6'd53;

    // White space: space, tab, newline, vertical tab, form feed, return.
    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    // Bytes that may open an identifier.
    function automatic logic is_ident_start(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"};
    endfunction

    // Operator bytes that may be followed by a second operator byte.
    function automatic logic can_extend(input logic [7:0] c);
        return c inside {"+", "-", "=", "!", "<", ">", "&", "|", "^", "*", "/", "%", ":"};
    endfunction

    // Kind of a lone operator byte; error kind when the byte is none.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "+":     k = KIND_ADD;
            "-":     k = KIND_SUB;
            "=":     k = KIND_ASSIGN;
            "!":     k = KIND_NOT;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            "&":     k = KIND_AND;
            "|":     k = KIND_OR;
            "^":     k = KIND_XOR;
            "~":     k = KIND_TILDE;
            "*":     k = KIND_MUL;
            "/":     k = KIND_DIV;
            "%":     k = KIND_MOD;
            "?":     k = KIND_QUEST;
            ":":     k = KIND_COLON;
            ";":     k = KIND_SEMI;
            ",":     k = KIND_COMMA;
            ".":     k = KIND_DOT;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // Kind of a two-byte operator; error kind when the pair is none.
    function automatic kind_t pair_kind(input logic [7:0] p, input logic [7:0] c);
        kind_t k;
        k = KIND_ERROR;
        if (c == "=")
        begin
            case (p)
                "+":     k = KIND_ADD_EQ;
                "-":     k = KIND_SUB_EQ;
                "=":     k = KIND_EQ_EQ;
                "!":     k = KIND_NOT_EQ;
                "<":     k = KIND_LE;
                ">":     k = KIND_GE;
                "&":     k = KIND_AND_EQ;
                "|":     k = KIND_OR_EQ;
                "^":     k = KIND_XOR_EQ;
                "*":     k = KIND_MUL_EQ;
                "/":     k = KIND_DIV_EQ;
                "%":     k = KIND_MOD_EQ;
                default: k = KIND_ERROR;
            endcase
        end
        else if (p == "+" && c == "+")
            k = KIND_INC;
        else if (p == "-" && c == "-")
            k = KIND_DEC;
        else if (p == "-" && c == ">")
            k = KIND_ARROW;
        else if (p == "&" && c == "&")
            k = KIND_LAND;
        else if (p == "|" && c == "|")
            k = KIND_LOR;
        else if (p == ":" && c == ":")
            k = KIND_SCOPE;
        return k;
    endfunction

endpackage

FILE: rtl/c_like_token_splitter_unit.sv
// Top level of the C-like token splitter: input register, scan step and a
// small result queue. Depends on ctks_pkg and ctks_scan_step.
//
// The block scans one source byte per cycle while it is not stalled. A byte
// is taken into an input register, and once the queue has room the scan step
// updates the mode, position and length registers and writes the zero, one or
// two tokens that the byte causes into a four-entry result queue, from whose
// head a token is offered on the output. The queue drains one token per cycle
// while the output is not stalled; the input register moves on only while
// the queue holds at most two tokens, so bytes that each close one token
// stream at one per cycle, and bytes that give two tokens are bounded by the
// one-token-per-cycle output. Line, column and length counters are
// COUNTER_BITS wide and saturate; reported fields are their low 16 bits.
module c_like_token_splitter_unit #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  ctks_pkg::char_item_t  char_item,
    output logic                  token_valid,
    input  logic                  token_stall,
    output ctks_pkg::token_item_t token_item
);
    import ctks_pkg::*;

    localparam int QueueDepth = 4;
    localparam int PtrBits    = $clog2(QueueDepth);
    localparam logic [PtrBits:0] QueueRoom = (PtrBits + 1)'(QueueDepth - 2);
    localparam logic [COUNTER_BITS-1:0] CountOne = COUNTER_BITS'(1);

    // Input register.
    logic       in_valid_reg;
    char_item_t in_item_reg;
    logic       char_accept;
    logic       step_go;

    // Scanner state.
    scan_ctl_t               ctl_reg;
    scan_ctl_t               ctl_next;
    logic [COUNTER_BITS-1:0] line_reg;
    logic [COUNTER_BITS-1:0] line_next;
    logic [COUNTER_BITS-1:0] col_reg;
    logic [COUNTER_BITS-1:0] col_next;
    logic [COUNTER_BITS-1:0] tline_reg;
    logic [COUNTER_BITS-1:0] tline_next;
    logic [COUNTER_BITS-1:0] tcol_reg;
    logic [COUNTER_BITS-1:0] tcol_next;
    logic [COUNTER_BITS-1:0] tcount_reg;
    logic [COUNTER_BITS-1:0] tcount_next;

    // Tokens from the scan step.
    token_item_t tok_first;
    token_item_t tok_second;
    logic [1:0]  tok_num;

    // Result queue.
    token_item_t        queue_reg [QueueDepth];
    logic [PtrBits-1:0] head_reg;
    logic [PtrBits-1:0] tail_reg;
    logic [PtrBits:0]   count_reg;
    logic [PtrBits-1:0] tail_plus_one;
    logic [1:0]         push_num;
    logic               pop;

    // The step runs when the queue has room for two more tokens.
    assign step_go     = in_valid_reg && (count_reg <= QueueRoom);
    assign char_stall  = in_valid_reg && !step_go;
    assign char_accept = char_valid && !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_accept)
            in_valid_reg <= 1'b1;
        else if (step_go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
            in_item_reg <= char_item;
    end

    ctks_scan_step #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_step (
        .item           (in_item_reg),
        .ctl            (ctl_reg),
        .cur_line       (line_reg),
        .cur_col        (col_reg),
        .tok_line       (tline_reg),
        .tok_col        (tcol_reg),
        .tok_count      (tcount_reg),
        .ctl_next       (ctl_next),
        .cur_line_next  (line_next),
        .cur_col_next   (col_next),
        .tok_line_next  (tline_next),
        .tok_col_next   (tcol_next),
        .tok_count_next (tcount_next),
        .tok_first      (tok_first),
        .tok_second     (tok_second),
        .tok_num        (tok_num)
    );

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.mode      <= MODE_IDLE;
            ctl_reg.op_first  <= 8'd0;
            ctl_reg.op_double <= 1'b0;
            line_reg          <= CountOne;
            col_reg           <= CountOne;
            tline_reg         <= CountOne;
            tcol_reg          <= CountOne;
            tcount_reg        <= '0;
        end
        else if (step_go)
        begin
            ctl_reg    <= ctl_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            tcount_reg <= tcount_next;
        end
    end

    // Result queue: up to two writes at the tail, one read at the head.
    assign push_num      = step_go ? tok_num : 2'd0;
    assign pop           = token_valid && !token_stall;
    assign tail_plus_one = tail_reg + PtrBits'(1);

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            queue_reg[tail_reg] <= tok_first;
        if (push_num == 2'd2)
            queue_reg[tail_plus_one] <= tok_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            tail_reg  <= tail_reg + PtrBits'(push_num);
            head_reg  <= head_reg + PtrBits'(pop);
            count_reg <= count_reg + (PtrBits + 1)'(push_num) - (PtrBits + 1)'(pop);
        end
    end

    assign token_valid = (count_reg != '0);
    assign token_item  = queue_reg[head_reg];

endmodule

FILE: rtl/ctks_scan_step.sv
// Combinational scan step: one source byte against the scanner state gives
// the next state and up to two tokens. Depends on ctks_pkg.
module ctks_scan_step #(
    parameter int COUNTER_BITS = 16
) (
    input  ctks_pkg::char_item_t  item,
    input  ctks_pkg::scan_ctl_t   ctl,
    input  logic [COUNTER_BITS-1:0] cur_line,
    input  logic [COUNTER_BITS-1:0] cur_col,
    input  logic [COUNTER_BITS-1:0] tok_line,
    input  logic [COUNTER_BITS-1:0] tok_col,
    input  logic [COUNTER_BITS-1:0] tok_count,
    output ctks_pkg::scan_ctl_t   ctl_next,
    output logic [COUNTER_BITS-1:0] cur_line_next,
    output logic [COUNTER_BITS-1:0] cur_col_next,
    output logic [COUNTER_BITS-1:0] tok_line_next,
    output logic [COUNTER_BITS-1:0] tok_col_next,
    output logic [COUNTER_BITS-1:0] tok_count_next,
    output ctks_pkg::token_item_t tok_first,
    output ctks_pkg::token_item_t tok_second,
    output logic [1:0]            tok_num
);
    import ctks_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CountOne = COUNTER_BITS'(1);

    // Saturating increment of a position or length counter.
    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        return (v == {COUNTER_BITS{1'b1}}) ? v : v + CountOne;
    endfunction

    logic [7:0]              c;
    logic [COUNTER_BITS-1:0] count_inc;
    logic                    a_valid;
    kind_t                   a_kind;
    logic [COUNTER_BITS-1:0] a_len;
    logic                    b_valid;
    kind_t                   b_kind;
    logic                    b_end;
    logic                    do_idle;
    token_item_t             a_tok;
    token_item_t             b_tok;

    assign c         = item.char_code;
    assign count_inc = sat_inc(tok_count);

    // Next state and the pending token (A) and a new one-byte token (B).
    always_comb
    begin
        ctl_next       = ctl;
        cur_line_next  = cur_line;
        cur_col_next   = cur_col;
        tok_line_next  = tok_line;
        tok_col_next   = tok_col;
        tok_count_next = tok_count;
        a_valid        = 1'b0;
        a_kind         = KIND_ERROR;
        a_len          = tok_count;
        b_valid        = 1'b0;
        b_kind         = KIND_ERROR;
        b_end          = 1'b0;
        do_idle        = 1'b0;

        if (item.end_of_text)
        begin
            // Flush the pending token, then give the end token.
            a_valid = 1'b1;
            case (ctl.mode)
                MODE_IDENT:     a_kind = KIND_IDENT;
                MODE_INT:       a_kind = KIND_INT;
                MODE_FRAC:      a_kind = KIND_FLOAT;
                MODE_STR, MODE_STR_ESC, MODE_CHR_OPEN, MODE_CHR_ESC, MODE_CHR_CLOSE:
                    a_kind = KIND_ERROR;
                MODE_DIR:       a_kind = KIND_DIRECTIVE;
                MODE_OP:
                begin
                    if (ctl.op_double)
                        a_kind = (ctl.op_first == "<") ? KIND_SHL : KIND_SHR;
                    else
                        a_kind = single_kind(ctl.op_first);
                end
                default:        a_valid = 1'b0;
            endcase
            b_valid = 1'b1;
            b_kind  = KIND_END;
            b_end   = 1'b1;

            // Back to the reset state.
            ctl_next.mode      = MODE_IDLE;
            ctl_next.op_first  = 8'd0;
            ctl_next.op_double = 1'b0;
            cur_line_next      = CountOne;
            cur_col_next       = CountOne;
            tok_line_next      = CountOne;
            tok_col_next       = CountOne;
            tok_count_next     = '0;
        end
        else
        begin
            // Extend or close the token in progress.
            case (ctl.mode)
                MODE_IDENT:
                begin
                    if (is_word(c))
                        tok_count_next = count_inc;
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_IDENT;
                        do_idle = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    if (is_digit(c) || c == ".")
                    begin
                        tok_count_next = count_inc;
                        if (c == ".")
                            ctl_next.mode = MODE_FRAC;
                    end
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_INT;
                        do_idle = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (is_digit(c))
                        tok_count_next = count_inc;
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_FLOAT;
                        do_idle = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    tok_count_next = count_inc;
                    if (c == "\\")
                        ctl_next.mode = MODE_STR_ESC;
                    else if (c == "\"")
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_STRING;
                        a_len   = count_inc;
                    end
                end
                MODE_STR_ESC:
                begin
                    tok_count_next = count_inc;
                    ctl_next.mode  = MODE_STR;
                end
                MODE_CHR_OPEN:
                begin
                    tok_count_next = count_inc;
                    ctl_next.mode  = (c == "\\") ? MODE_CHR_ESC : MODE_CHR_CLOSE;
                end
                MODE_CHR_ESC:
                begin
                    tok_count_next = count_inc;
                    ctl_next.mode  = MODE_CHR_CLOSE;
                end
                MODE_CHR_CLOSE:
                begin
                    a_valid = 1'b1;
                    if (c == "'")
                    begin
                        tok_count_next = count_inc;
                        a_kind         = KIND_CHAR;
                        a_len          = count_inc;
                    end
                    else
                    begin
                        a_kind  = KIND_ERROR;
                        do_idle = 1'b1;
                    end
                end
                MODE_DIR:
                begin
                    if (c == "\n")
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_DIRECTIVE;
                    end
                    else
                        tok_count_next = count_inc;
                end
                MODE_LINE_CMT:
                begin
                    if (c == "\n")
                        ctl_next.mode = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (c == "*")
                        ctl_next.mode = MODE_BLOCK_STAR;
                end
                MODE_BLOCK_STAR:
                begin
                    if (c == "/")
                        ctl_next.mode = MODE_IDLE;
                    else if (c != "*")
                        ctl_next.mode = MODE_BLOCK;
                end
                MODE_OP:
                begin
                    if (ctl.op_double)
                    begin
                        // A shift pair is pending: only '=' extends it.
                        a_valid = 1'b1;
                        if (c == "=")
                        begin
                            tok_count_next = count_inc;
                            a_len          = count_inc;
                            a_kind = (ctl.op_first == "<") ? KIND_SHL_EQ : KIND_SHR_EQ;
                        end
                        else
                        begin
                            a_kind  = (ctl.op_first == "<") ? KIND_SHL : KIND_SHR;
                            do_idle = 1'b1;
                        end
                    end
                    else if (ctl.op_first == "/" && c == "/")
                    begin
                        ctl_next.mode     = MODE_LINE_CMT;
                        ctl_next.op_first = 8'd0;
                    end
                    else if (ctl.op_first == "/" && c == "*")
                    begin
                        ctl_next.mode     = MODE_BLOCK;
                        ctl_next.op_first = 8'd0;
                    end
                    else if ((ctl.op_first == "<" || ctl.op_first == ">") && c == ctl.op_first)
                    begin
                        ctl_next.op_double = 1'b1;
                        tok_count_next     = count_inc;
                    end
                    else if (pair_kind(ctl.op_first, c) != KIND_ERROR)
                    begin
                        a_valid        = 1'b1;
                        a_kind         = pair_kind(ctl.op_first, c);
                        tok_count_next = count_inc;
                        a_len          = count_inc;
                    end
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = single_kind(ctl.op_first);
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    ctl_next.mode = MODE_IDLE;
                    do_idle       = 1'b1;
                end
            endcase

            // Closing the pending token returns the scanner to idle.
            if (a_valid)
            begin
                ctl_next.mode      = MODE_IDLE;
                ctl_next.op_first  = 8'd0;
                ctl_next.op_double = 1'b0;
            end

            // Handle the byte as the start of new text.
            if (do_idle && !is_space(c))
            begin
                if (is_ident_start(c) || is_digit(c) || c == "\"" || c == "'" || c == "#"
                    || can_extend(c))
                begin
                    tok_line_next  = cur_line;
                    tok_col_next   = cur_col;
                    tok_count_next = CountOne;
                    if (is_ident_start(c))
                        ctl_next.mode = MODE_IDENT;
                    else if (is_digit(c))
                        ctl_next.mode = MODE_INT;
                    else if (c == "\"")
                        ctl_next.mode = MODE_STR;
                    else if (c == "'")
                        ctl_next.mode = MODE_CHR_OPEN;
                    else if (c == "#")
                        ctl_next.mode = MODE_DIR;
                    else
                    begin
                        ctl_next.mode      = MODE_OP;
                        ctl_next.op_first  = c;
                        ctl_next.op_double = 1'b0;
                    end
                end
                else
                begin
                    b_valid = 1'b1;
                    b_kind  = single_kind(c);
                end
            end

            // Advance the source position.
            if (c == "\n")
            begin
                cur_line_next = sat_inc(cur_line);
                cur_col_next  = CountOne;
            end
            else
                cur_col_next = sat_inc(cur_col);
        end
    end

    // Assemble the tokens in order; the pending one comes first.
    always_comb
    begin
        a_tok.token_kind   = a_kind;
        a_tok.start_line   = 16'(tok_line);
        a_tok.start_column = 16'(tok_col);
        a_tok.token_length = 16'(a_len);
        a_tok.last_of_run  = !b_valid;

        b_tok.token_kind   = b_kind;
        b_tok.start_line   = 16'(cur_line);
        b_tok.start_column = 16'(cur_col);
        b_tok.token_length = b_end ? 16'd0 : 16'd1;
        b_tok.last_of_run  = 1'b1;

        tok_first  = a_valid ? a_tok : b_tok;
        tok_second = b_tok;
        tok_num    = {1'b0, a_valid} + {1'b0, b_valid};
    end

endmodule
